@@ sv/pbpm_pkg.sv @@
// shared types, constants and helpers for the packet buffer pool manager
package pbpm_pkg;

	localparam int NUM_BUFFERS = 16;
	localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam int LINK_W = $clog2(NUM_BUFFERS + 1);
	localparam int BYTES_W = 11;
	localparam int BI_W = 4;
	localparam int OUT_IDX_W = 4;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [LINK_W-1:0] link_t;
	typedef logic [BYTES_W-1:0] bytes_t;

	localparam link_t LINK_NULL = LINK_W'(NUM_BUFFERS);
	localparam bytes_t MAX_BYTES_RESET = 11'd1514;

	typedef enum logic [1:0] {
		CMD_ACQUIRE = 2'd0,
		CMD_MARK_READY = 2'd1,
		CMD_GET_READY = 2'd2,
		CMD_RELEASE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_OVER = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PHASE_FREE = 2'd0,
		PHASE_PENDING = 2'd1,
		PHASE_READY = 2'd2,
		PHASE_USER = 2'd3
	} phase_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		phase_t phase;
		bytes_t len;
	} desc_t;

	typedef struct packed {
		logic rd_en;
		idx_t rd_addr;
		logic wr_en;
		idx_t wr_addr;
		link_t wr_data;
	} link_req_t;

	typedef struct packed {
		logic rd_en;
		idx_t rd_addr;
		logic wr_en;
		idx_t wr_addr;
		desc_t wr_data;
	} desc_req_t;

	function automatic logic bi_in_range(logic [BI_W-1:0] b);
		return 32'(b) < 32'(NUM_BUFFERS);
	endfunction

	function automatic idx_t bi_to_idx(logic [BI_W-1:0] b);
		return IDX_W'(b);
	endfunction

	function automatic logic is_null(link_t l);
		return l >= LINK_NULL;
	endfunction

endpackage

@@ sv/packet_buffer_pool_manager_top.sv @@
// top level of the packet buffer pool manager: sequencer plus link and descriptor memories
// latency: a command accepted at one edge gives its result, with done high, in the next cycle
// busy is high in the cycle after each transfer, so no new command is taken before the last is done,
//   while the link and descriptor memories are read, then written back
// reset: asynchronous, active low; free list chains all buffers, ready list empty, limit 1514
// results cannot be stalled: done is a single-cycle strobe
module packet_buffer_pool_manager_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  cmd,
	input  logic [pbpm_pkg::BI_W-1:0]   buf_index,
	input  pbpm_pkg::bytes_t            req_bytes,
	input  logic                        cfg_we,
	input  pbpm_pkg::bytes_t            cfg_wdata,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [pbpm_pkg::OUT_IDX_W-1:0] out_index,
	output pbpm_pkg::bytes_t            out_bytes
);
	import pbpm_pkg::*;

	link_req_t link_req;
	link_t link_rdata;
	desc_req_t desc_req;
	desc_t desc_rdata;

	pbpm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.buf_index  (buf_index),
		.req_bytes  (req_bytes),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.status     (status),
		.out_index  (out_index),
		.out_bytes  (out_bytes),
		.link_req   (link_req),
		.link_rdata (link_rdata),
		.desc_req   (desc_req),
		.desc_rdata (desc_rdata)
	);

	pbpm_link_mem u_link_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (link_req),
		.rdata  (link_rdata)
	);

	pbpm_desc_mem u_desc_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (desc_req),
		.rdata  (desc_rdata)
	);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("no result in the cycle after a command transfer");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != STATUS_OK |-> out_index == '0 && out_bytes == '0)
		else $error("failed result carries nonzero fields");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !link_req.wr_en && !desc_req.wr_en)
		else $error("memory write outside the execute cycle");

endmodule

@@ sv/pbpm_link_mem.sv @@
// next-pointer memory with per-entry valid bits, unwritten entries read as chained
module pbpm_link_mem (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pbpm_pkg::link_req_t   req,
	output pbpm_pkg::link_t       rdata
);
	import pbpm_pkg::*;

	link_t mem [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0] valid_q;
	link_t rdata_q;
	logic rvalid_q;
	idx_t raddr_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.rd_addr];
			raddr_q <= req.rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvalid_q <= valid_q[req.rd_addr];
			end
		end
	end

	// reset chain: entry i links to i+1
	assign rdata = rvalid_q ? rdata_q : (LINK_W'(raddr_q) + LINK_W'(1));

endmodule

@@ sv/pbpm_desc_mem.sv @@
// descriptor memory holding phase and byte count, unwritten entries read as free and empty
module pbpm_desc_mem (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pbpm_pkg::desc_req_t   req,
	output pbpm_pkg::desc_t       rdata
);
	import pbpm_pkg::*;

	desc_t mem [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0] valid_q;
	desc_t rdata_q;
	logic rvalid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvalid_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '{phase: PHASE_FREE, len: '0};

endmodule

@@ sv/pbpm_ctrl.sv @@
// command sequencer: list heads, limit register and read-modify-write of both memories
module pbpm_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  cmd,
	input  logic [pbpm_pkg::BI_W-1:0]   buf_index,
	input  pbpm_pkg::bytes_t            req_bytes,
	input  logic                        cfg_we,
	input  pbpm_pkg::bytes_t            cfg_wdata,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [pbpm_pkg::OUT_IDX_W-1:0] out_index,
	output pbpm_pkg::bytes_t            out_bytes,
	output pbpm_pkg::link_req_t         link_req,
	input  pbpm_pkg::link_t             link_rdata,
	output pbpm_pkg::desc_req_t         desc_req,
	input  pbpm_pkg::desc_t             desc_rdata
);
	import pbpm_pkg::*;

	state_t state_q, state_d;
	cmd_t cmd_q;
	logic [BI_W-1:0] bi_q;
	bytes_t req_q;
	bytes_t max_bytes_q;
	link_t free_head_q, free_head_d;
	link_t ready_head_q, ready_head_d;
	logic accept;

	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = (state_q == ST_EXEC);
		done = 1'b0;
		status = STATUS_OK;
		out_index = '0;
		out_bytes = '0;
		free_head_d = free_head_q;
		ready_head_d = ready_head_q;
		link_req = '0;
		desc_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				// issue the reads the command will need next cycle
				if (accept) begin
					unique case (cmd_t'(cmd))
						CMD_ACQUIRE: begin
							link_req.rd_en = !is_null(free_head_q);
							link_req.rd_addr = idx_t'(free_head_q);
						end
						CMD_GET_READY: begin
							link_req.rd_en = !is_null(ready_head_q);
							link_req.rd_addr = idx_t'(ready_head_q);
							desc_req.rd_en = !is_null(ready_head_q);
							desc_req.rd_addr = idx_t'(ready_head_q);
						end
						CMD_MARK_READY: begin
							desc_req.rd_en = bi_in_range(buf_index);
							desc_req.rd_addr = bi_to_idx(buf_index);
						end
						CMD_RELEASE: begin
						end
						default: begin
						end
					endcase
				end
			end
			ST_EXEC: begin
				done = 1'b1;
				unique case (cmd_q)
					CMD_ACQUIRE: begin
						if (is_null(free_head_q)) begin
							status = STATUS_EMPTY;
						end else if (req_q > max_bytes_q) begin
							status = STATUS_OVER;
						end else begin
							out_index = OUT_IDX_W'(idx_t'(free_head_q));
							free_head_d = link_rdata;
							link_req.wr_en = 1'b1;
							link_req.wr_addr = idx_t'(free_head_q);
							link_req.wr_data = LINK_NULL;
							desc_req.wr_en = 1'b1;
							desc_req.wr_addr = idx_t'(free_head_q);
							desc_req.wr_data = '{phase: PHASE_PENDING, len: req_q};
						end
					end
					CMD_MARK_READY: begin
						if (bi_in_range(bi_q)) begin
							ready_head_d = LINK_W'(bi_to_idx(bi_q));
							link_req.wr_en = 1'b1;
							link_req.wr_addr = bi_to_idx(bi_q);
							link_req.wr_data = ready_head_q;
							desc_req.wr_en = 1'b1;
							desc_req.wr_addr = bi_to_idx(bi_q);
							desc_req.wr_data = '{phase: PHASE_READY, len: desc_rdata.len};
						end
					end
					CMD_GET_READY: begin
						if (is_null(ready_head_q)) begin
							status = STATUS_EMPTY;
						end else begin
							out_index = OUT_IDX_W'(idx_t'(ready_head_q));
							out_bytes = desc_rdata.len;
							ready_head_d = link_rdata;
							link_req.wr_en = 1'b1;
							link_req.wr_addr = idx_t'(ready_head_q);
							link_req.wr_data = LINK_NULL;
							desc_req.wr_en = 1'b1;
							desc_req.wr_addr = idx_t'(ready_head_q);
							desc_req.wr_data = '{phase: PHASE_USER, len: desc_rdata.len};
						end
					end
					CMD_RELEASE: begin
						if (bi_in_range(bi_q)) begin
							free_head_d = LINK_W'(bi_to_idx(bi_q));
							link_req.wr_en = 1'b1;
							link_req.wr_addr = bi_to_idx(bi_q);
							link_req.wr_data = free_head_q;
							desc_req.wr_en = 1'b1;
							desc_req.wr_addr = bi_to_idx(bi_q);
							desc_req.wr_data = '{phase: PHASE_FREE, len: '0};
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			free_head_q <= '0;
			ready_head_q <= LINK_NULL;
			max_bytes_q <= MAX_BYTES_RESET;
		end else begin
			state_q <= state_d;
			free_head_q <= free_head_d;
			ready_head_q <= ready_head_d;
			if (cfg_we) begin
				max_bytes_q <= cfg_wdata;
			end
		end
	end

	// command transfer capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(cmd);
			bi_q <= buf_index;
			req_q <= req_bytes;
		end
	end

endmodule

@@ verif/tb.sv @@
// self-checking testbench for the packet buffer pool manager: directed and random command traffic
module tb;
	import pbpm_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 140;

	typedef struct packed {
		status_t st;
		logic [OUT_IDX_W-1:0] idx;
		bytes_t bytes;
	} grant_t;

	class pool_scoreboard;
		link_t link_tbl[NUM_BUFFERS];
		phase_t phase_tbl[NUM_BUFFERS];
		bytes_t len_tbl[NUM_BUFFERS];
		link_t free_top;
		link_t ready_top;
		bytes_t size_limit;
		grant_t grants_due[$];
		int errors;

		function new();
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				link_tbl[i] = LINK_W'(i + 1);
				phase_tbl[i] = PHASE_FREE;
				len_tbl[i] = '0;
			end
			free_top = '0;
			ready_top = LINK_W'(NUM_BUFFERS);
			size_limit = 11'd1514;
			errors = 0;
		endfunction

		function void set_limit(bytes_t v);
			size_limit = v;
		endfunction

		function void apply_command(cmd_t c, logic [BI_W-1:0] bi, bytes_t rb);
			grant_t g;
			int node;
			g = '{st: STATUS_OK, idx: '0, bytes: '0};
			case (c)
				CMD_ACQUIRE: begin
					if (int'(free_top) >= NUM_BUFFERS) begin
						g.st = STATUS_EMPTY;
					end else if (rb > size_limit) begin
						g.st = STATUS_OVER;
					end else begin
						node = int'(free_top);
						free_top = link_tbl[node];
						len_tbl[node] = rb;
						phase_tbl[node] = PHASE_PENDING;
						link_tbl[node] = LINK_W'(NUM_BUFFERS);
						g.idx = OUT_IDX_W'(node);
					end
				end
				CMD_MARK_READY: begin
					if (int'(bi) < NUM_BUFFERS) begin
						phase_tbl[bi] = PHASE_READY;
						link_tbl[bi] = ready_top;
						ready_top = LINK_W'(bi);
					end
				end
				CMD_GET_READY: begin
					if (int'(ready_top) >= NUM_BUFFERS) begin
						g.st = STATUS_EMPTY;
					end else begin
						node = int'(ready_top);
						ready_top = link_tbl[node];
						phase_tbl[node] = PHASE_USER;
						link_tbl[node] = LINK_W'(NUM_BUFFERS);
						g.idx = OUT_IDX_W'(node);
						g.bytes = len_tbl[node];
					end
				end
				default: begin
					if (int'(bi) < NUM_BUFFERS) begin
						phase_tbl[bi] = PHASE_FREE;
						len_tbl[bi] = '0;
						link_tbl[bi] = free_top;
						free_top = LINK_W'(bi);
					end
				end
			endcase
			grants_due.push_back(g);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [1:0] st, logic [OUT_IDX_W-1:0] idx, bytes_t b);
			grant_t g;
			if (grants_due.size() == 0) begin
				report($sformatf("result st=%0d idx=%0d bytes=%0d with no transfer pending",
					st, idx, b));
			end else begin
				g = grants_due.pop_front();
				if (st !== g.st)
					report($sformatf("status %0d, want %0d", st, g.st));
				if (idx !== g.idx)
					report($sformatf("out_index %0d, want %0d", idx, g.idx));
				if (b !== g.bytes)
					report($sformatf("out_bytes %0d, want %0d", b, g.bytes));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] cmd;
	logic [BI_W-1:0] buf_index;
	bytes_t req_bytes;
	logic cfg_we;
	bytes_t cfg_wdata;
	logic done;
	logic [1:0] status;
	logic [OUT_IDX_W-1:0] out_index;
	bytes_t out_bytes;

	pool_scoreboard sb;
	int quiet_cycles = 0;

	packet_buffer_pool_manager_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.buf_index(buf_index),
		.req_bytes(req_bytes),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.status(status),
		.out_index(out_index),
		.out_bytes(out_bytes)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic send_cmd(cmd_t c, logic [BI_W-1:0] bi, bytes_t rb, int idle_pct);
		int gap = 0;
		while (gap < 24 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		buf_index <= bi;
		req_bytes <= rb;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.apply_command(c, bi, rb);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.grants_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_limit(bytes_t v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(v);
	endtask

	function automatic bytes_t pick_req(bytes_t lim);
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return bytes_t'($urandom_range(int'(lim), 0));
		if (r < 90)
			return bytes_t'($urandom);
		case ($urandom_range(3))
			0: return '0;
			1: return lim;
			2: return lim + 1'b1;
			default: return '1;
		endcase
	endfunction

	task automatic random_item(int idle_pct);
		int r;
		cmd_t c;
		logic [BI_W-1:0] bi;
		bytes_t rb;
		int held[$];
		int owned[$];
		bi = BI_W'($urandom);
		rb = bytes_t'($urandom);
		if ($urandom_range(99) < 15) begin
			c = cmd_t'($urandom_range(3));
		end else begin
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				if (sb.phase_tbl[i] == PHASE_PENDING)
					held.push_back(i);
				if (sb.phase_tbl[i] == PHASE_USER)
					owned.push_back(i);
			end
			r = $urandom_range(99);
			if (r < 35 || (r < 60 && held.size() == 0)) begin
				c = CMD_ACQUIRE;
				rb = pick_req(sb.size_limit);
			end else if (r < 60) begin
				c = CMD_MARK_READY;
				bi = BI_W'(held[$urandom_range(held.size() - 1)]);
			end else if (r < 80 || owned.size() == 0) begin
				c = CMD_GET_READY;
			end else begin
				c = CMD_RELEASE;
				bi = BI_W'(owned[$urandom_range(owned.size() - 1)]);
			end
		end
		if ($urandom_range(199) == 0)
			drain();
		send_cmd(c, bi, rb, idle_pct);
	endtask

	// check results and watch for a stalled run
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(status, out_index, out_bytes);
			if (done || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		bytes_t limits[PHASES];
		int idle_pcts[PHASES];
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_ACQUIRE;
		buf_index = '0;
		req_bytes = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		limits = '{11'd2047, 11'd0, bytes_t'($urandom), 11'd1, 11'd2046, 11'd1514};
		idle_pcts = '{0, 60, 24, 0, 60, 24};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset limit, size edges, empty ready list, lifo order
		send_cmd(CMD_ACQUIRE, 4'd0, 11'd0, 0);
		send_cmd(CMD_ACQUIRE, 4'd0, 11'd1514, 0);
		send_cmd(CMD_ACQUIRE, 4'd0, 11'd1515, 0);
		send_cmd(CMD_ACQUIRE, 4'd0, 11'd2047, 0);
		send_cmd(CMD_GET_READY, 4'd0, 11'd0, 0);
		send_cmd(CMD_MARK_READY, 4'd1, 11'd0, 0);
		send_cmd(CMD_MARK_READY, 4'd0, 11'd0, 0);
		send_cmd(CMD_GET_READY, 4'd0, 11'd0, 0);
		send_cmd(CMD_GET_READY, 4'd0, 11'd0, 0);
		send_cmd(CMD_GET_READY, 4'd0, 11'd0, 0);
		send_cmd(CMD_RELEASE, 4'd1, 11'd0, 0);
		send_cmd(CMD_RELEASE, 4'd0, 11'd0, 0);
		// free buffer pushed on the ready list without a check
		send_cmd(CMD_MARK_READY, 4'd15, 11'h7ff, 0);
		send_cmd(CMD_GET_READY, 4'd0, 11'd0, 0);
		write_limit(11'd2047);
		send_cmd(CMD_ACQUIRE, 4'd15, 11'd2047, 0);
		write_limit(11'd0);
		send_cmd(CMD_ACQUIRE, 4'd0, 11'd0, 0);
		send_cmd(CMD_ACQUIRE, 4'd0, 11'd1, 0);
		// further zero-byte acquires, each at the limit of zero
		for (int i = 0; i < 4; i++)
			send_cmd(CMD_ACQUIRE, 4'd0, 11'd0, 0);
		write_limit(11'd1514);

		for (int p = 0; p < PHASES; p++) begin
			write_limit(limits[p]);
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_item(idle_pcts[p]);
		end

		drain();
		repeat (4) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
